/* rtl/core/swq_pkg.sv */
// shared types and constants for the skin weight quantizer
// no dependencies
`timescale 1ns / 1ps
package swq_pkg;
    localparam int MAX_JOINTS_DEF = 256;
    localparam logic [7:0] UNMAPPED = 8'hFF;
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;
endpackage

/* rtl/core/skin_weight_quantizer_unit.sv */
// skin weight quantizer top level: remap lookup, four divider pipes, correction
// depends on swq_pkg and swq_div
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tdata, tuser = req_type
// m_       out  m_tvalid/m_tready  tdata
// cfg_     in   cfg_valid/ready    cfg_data = joint_count
//
// one item per cycle while the pipe advances; 12 register stages: table read, mask
// and total, numerator, eight divider steps, correction into the output register.
// the whole pipe advances when the output register is free or being taken.
// write items update the table at acceptance and make no result; a written mask
// makes entries read as unmapped until first written, so no clearing pass.
`timescale 1ns / 1ps
module skin_weight_quantizer_unit
    import swq_pkg::*;
#(
    parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,  // remap_slot, remap_value, joint_in0..3, weight_in0..3
    input  logic         s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,  // joint_out0..3, weight_out0..3, dominant_slot,
                                   // dominant_joint, 6 zero bits
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [8:0]   cfg_data
);
    localparam int IW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    // two copies of the table, each read at two addresses a cycle
    logic [7:0] table_reg [0:MAX_JOINTS-1];
    logic [7:0] table_b_reg [0:MAX_JOINTS-1];
    logic [MAX_JOINTS-1:0] written_reg;
    logic [7:0] entry0_reg;
    logic [8:0] jcount_reg;
    logic en, acc, wr_en;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) jcount_reg <= '0;
        else if (cfg_valid && cfg_ready) jcount_reg <= cfg_data;
    end

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;
    assign acc = s_tvalid && s_tready;

    logic [7:0]  wslot;
    assign wslot = s_tdata[7:0];
    assign wr_en = acc && s_tuser == REQ_WRITE && {1'b0, wslot} < 9'(MAX_JOINTS);

    logic [8:0] limit;
    assign limit = (jcount_reg > 9'(MAX_JOINTS)) ? 9'(MAX_JOINTS) : jcount_reg;

    logic [15:0] ix [0:3];
    always_comb begin
        for (int k = 0; k < 4; k++) ix[k] = s_tdata[16+16*k +: 16];
    end

    // stage 1: registered table reads, range and written flags, entry 0 for zero total
    logic        v1_reg;
    logic [7:0]  e1a_reg [0:1];
    logic [7:0]  e1b_reg [0:1];
    logic [3:0]  hit1_reg;
    logic [8:0]  z1_reg;
    logic [15:0] w1_reg [0:3];
    always_ff @(posedge aclk) begin
        if (wr_en) table_reg[wslot[IW-1:0]] <= s_tdata[15:8];
        if (en) begin
            e1a_reg[0] <= table_reg[ix[0][IW-1:0]];
            e1a_reg[1] <= table_reg[ix[1][IW-1:0]];
        end
    end
    always_ff @(posedge aclk) begin
        if (wr_en) table_b_reg[wslot[IW-1:0]] <= s_tdata[15:8];
        if (en) begin
            e1b_reg[0] <= table_b_reg[ix[2][IW-1:0]];
            e1b_reg[1] <= table_b_reg[ix[3][IW-1:0]];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) written_reg <= '0;
        else if (wr_en) written_reg[wslot[IW-1:0]] <= 1'b1;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) entry0_reg <= UNMAPPED;
        else if (wr_en && wslot == 8'd0) entry0_reg <= s_tdata[15:8];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= acc && s_tuser == REQ_VERTEX;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                hit1_reg[k] <= (ix[k] < {7'b0, limit}) && written_reg[ix[k][IW-1:0]];
                w1_reg[k]   <= s_tdata[80+16*k +: 16];
            end
            z1_reg <= {(limit != 9'd0) && (entry0_reg != UNMAPPED), entry0_reg};
        end
    end

    // stage 2: masked weights, total, zero-total substitution, joints
    logic        v2_reg;
    logic [15:0] w2_reg [0:3];
    logic [7:0]  j2_reg [0:3];
    logic [17:0] t2_reg;
    logic [7:0]  e1 [0:3];
    logic [3:0]  mapped;
    logic [15:0] wm [0:3];
    logic [7:0]  jm [0:3];
    logic [17:0] tsum;
    logic [15:0] w2_next [0:3];
    logic [7:0]  j2_next [0:3];
    logic [17:0] t2_next;
    always_comb begin
        e1[0] = e1a_reg[0];
        e1[1] = e1a_reg[1];
        e1[2] = e1b_reg[0];
        e1[3] = e1b_reg[1];
        for (int k = 0; k < 4; k++) begin
            mapped[k] = hit1_reg[k] && (e1[k] != UNMAPPED);
            wm[k] = mapped[k] ? w1_reg[k] : 16'd0;
            jm[k] = mapped[k] ? e1[k] : 8'd0;
        end
        tsum = 18'(wm[0]) + 18'(wm[1]) + 18'(wm[2]) + 18'(wm[3]);
        for (int k = 0; k < 4; k++) begin
            w2_next[k] = wm[k];
            j2_next[k] = jm[k];
        end
        t2_next = tsum;
        if (tsum == 18'd0) begin
            w2_next[0] = 16'hFFFF;
            t2_next    = 18'd65535;
            j2_next[0] = z1_reg[8] ? z1_reg[7:0] : 8'd0;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                w2_reg[k] <= w2_next[k];
                j2_reg[k] <= j2_next[k];
            end
            t2_reg <= t2_next;
        end
    end

    // stage 3: numerators and best slot
    logic        v3_reg;
    logic [25:0] n3_reg [0:3];
    logic [18:0] d3_reg;
    logic [1:0]  b3_reg;
    logic [31:0] j3_reg;
    logic [1:0]  best;
    always_comb begin
        best = 2'd0;
        for (int k = 1; k < 4; k++) if (w2_reg[k] > w2_reg[best]) best = 2'(k);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++)
                n3_reg[k] <= 26'(w2_reg[k]) * 26'd510 + 26'(t2_reg);
            d3_reg <= {t2_reg, 1'b0};
            b3_reg <= best;
            j3_reg <= {j2_reg[3], j2_reg[2], j2_reg[1], j2_reg[0]};
        end
    end

    localparam int TW = 34;
    logic [7:0]    q4 [0:3];
    logic [3:0]    v4;
    logic [TW-1:0] tag4 [0:3];
    for (genvar k = 0; k < 4; k++) begin : g_div
        swq_div #(.TAG_W(TW)) u_div (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(v3_reg), .in_num(n3_reg[k]), .in_den(d3_reg),
            .in_tag({b3_reg, j3_reg}),
            .out_valid(v4[k]), .out_q(q4[k]), .out_tag(tag4[k])
        );
    end

    // correction and output register
    logic [9:0]  asum;
    logic [10:0] corr;
    logic [7:0]  qf [0:3];
    logic [1:0]  bs;
    logic [31:0] js;
    always_comb begin
        bs = tag4[0][33:32];
        js = tag4[0][31:0];
        asum = 10'(q4[0]) + 10'(q4[1]) + 10'(q4[2]) + 10'(q4[3]);
        corr = 11'(q4[bs]) + 11'd255 - 11'(asum);
        for (int k = 0; k < 4; k++) qf[k] = q4[k];
        if (corr[10]) qf[bs] = 8'd0;
        else if (corr > 11'd255) qf[bs] = 8'd255;
        else qf[bs] = corr[7:0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (en) m_tvalid <= v4[0];
    end
    always_ff @(posedge aclk) begin
        if (en) m_tdata <= {6'd0, js[8*bs +: 8], bs,
                            qf[3], qf[2], qf[1], qf[0], js};
    end
endmodule

/* rtl/core/swq_div.sv */
// restoring divider, one quotient bit per pipeline stage, 8-bit quotient
// depends on nothing; no saturation: the quotient is exact only for num < 256*den
`timescale 1ns / 1ps
module swq_div #(
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [25:0]      in_num,
    input  logic [18:0]      in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [7:0]       out_q,
    output logic [TAG_W-1:0] out_tag
);
    // num < 256*den is guaranteed here (510w+t < 512t), so 8 steps suffice
    logic [25:0]      rem_reg [1:8];
    logic [18:0]      den_reg [1:8];
    logic [7:0]       q_reg   [1:8];
    logic [TAG_W-1:0] tag_reg [1:8];
    logic [8:1]       v_reg;

    for (genvar s = 0; s < 8; s++) begin : g_step
        logic [25:0]      rem_in;
        logic [18:0]      den_in;
        logic [7:0]       q_in;
        logic [TAG_W-1:0] tag_in;
        logic             v_in;
        logic [27:0]      sub;
        if (s == 0) begin : g_first
            assign rem_in = in_num;
            assign den_in = in_den;
            assign q_in   = '0;
            assign tag_in = in_tag;
            assign v_in   = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[s];
            assign den_in = den_reg[s];
            assign q_in   = q_reg[s];
            assign tag_in = tag_reg[s];
            assign v_in   = v_reg[s];
        end
        assign sub = {2'b0, rem_in} - ({9'b0, den_in} << (7 - s));
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1] <= sub[27] ? rem_in : sub[25:0];
                q_reg[s+1]   <= {q_in[6:0], ~sub[27]};
                den_reg[s+1] <= den_in;
                tag_reg[s+1] <= tag_in;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg[s+1] <= 1'b0;
            else if (en) v_reg[s+1] <= v_in;
        end
    end

    assign out_valid = v_reg[8];
    assign out_q     = q_reg[8];
    assign out_tag   = tag_reg[8];
endmodule

/* tb/skin_weight_quantizer_unit_test.sv */
// testbench for skin_weight_quantizer_unit: remap writes, vertex quantization, joint_count
// depends on swq_pkg and the rtl of skin_weight_quantizer_unit
`timescale 1ns / 1ps
module skin_weight_quantizer_unit_test;
    import swq_pkg::*;

    // lowest field last, matching m_tdata from bit 0 up
    typedef struct packed {
        logic [7:0] dom_joint;
        logic [1:0] dom_slot;
        logic [7:0] w3, w2, w1, w0;
        logic [7:0] j3, j2, j1, j0;
    } vertex_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [8:0]   cfg_data = '0;

    logic [7:0]   joint_map [256];
    logic [8:0]   active_joints;
    vertex_out_t  pending_vertices [$];
    int           errors = 0;
    bit           rx_enable = 1'b0;
    bit           rx_free_run = 1'b0;
    bit           tx_free_run = 1'b0;

    skin_weight_quantizer_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("skin_weight_quantizer_unit_test: FAIL");
        $finish;
    end

    function automatic bit map_joint(input logic [15:0] idx, output logic [7:0] joint);
        int lim;
        lim = (active_joints > 9'd256) ? 256 : int'(active_joints);
        joint = 8'd0;
        if (idx >= lim) return 1'b0;
        if (joint_map[idx[7:0]] == UNMAPPED) return 1'b0;
        joint = joint_map[idx[7:0]];
        return 1'b1;
    endfunction

    function automatic vertex_out_t quantize_vertex(input logic [15:0] ji [4],
                                                    input logic [15:0] wi [4]);
        logic [15:0] idx [4];
        logic [17:0] w [4];
        logic [17:0] total;
        logic [7:0]  jo [4];
        int unsigned q [4];
        int          assigned, corr, best;
        logic [7:0]  j;
        vertex_out_t r;
        total = '0;
        assigned = 0;
        best = 0;
        for (int k = 0; k < 4; k++) begin
            idx[k] = ji[k];
            w[k] = map_joint(ji[k], j) ? 18'(wi[k]) : 18'd0;
            total += w[k];
        end
        if (total == 18'd0) begin
            w[0] = 18'd65535;
            total = 18'd65535;
            idx[0] = 16'd0;
        end
        for (int k = 0; k < 4; k++) begin
            void'(map_joint(idx[k], j));
            jo[k] = j;
            q[k] = 32'((64'(510) * w[k] + total) / (64'(2) * total));
            if (q[k] > 255) q[k] = 255;
            assigned += int'(q[k]);
            if (w[k] > w[best]) best = k;
        end
        corr = int'(q[best]) + 255 - assigned;
        if (corr < 0) corr = 0;
        if (corr > 255) corr = 255;
        q[best] = corr;
        r.j0 = jo[0]; r.j1 = jo[1]; r.j2 = jo[2]; r.j3 = jo[3];
        r.w0 = q[0][7:0]; r.w1 = q[1][7:0]; r.w2 = q[2][7:0]; r.w3 = q[3][7:0];
        r.dom_slot = best[1:0];
        r.dom_joint = jo[best];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s exp %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    // one item on the s_ channel; predictor updated at acceptance
    task automatic send_item(input logic req, input logic [7:0] slot, input logic [7:0] val,
                             input logic [15:0] ji [4], input logic [15:0] wi [4]);
        int gap;
        gap = tx_free_run ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser <= req;
        s_tdata <= {wi[3], wi[2], wi[1], wi[0], ji[3], ji[2], ji[1], ji[0], val, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (req == REQ_WRITE) joint_map[slot] = val;
        else pending_vertices.insert(pending_vertices.size(), quantize_vertex(ji, wi));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_write(input logic [7:0] slot, input logic [7:0] val);
        logic [15:0] ji [4];
        logic [15:0] wi [4];
        foreach (ji[k]) begin
            ji[k] = 16'($urandom);
            wi[k] = 16'($urandom);
        end
        send_item(REQ_WRITE, slot, val, ji, wi);
    endtask

    task automatic send_vertex(input logic [15:0] ji [4], input logic [15:0] wi [4]);
        send_item(REQ_VERTEX, 8'($urandom), 8'($urandom), ji, wi);
    endtask

    // wait for every vertex to drain, then margin for the pipe before a register write
    task automatic drain_and_configure(input logic [8:0] count);
        while (pending_vertices.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        active_joints = count;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : result_checker
        vertex_out_t got, want;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = m_tdata[73:0];
                if (pending_vertices.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_vertices.pop_front();
                    check_field("joint_out0", want.j0, got.j0);
                    check_field("joint_out1", want.j1, got.j1);
                    check_field("joint_out2", want.j2, got.j2);
                    check_field("joint_out3", want.j3, got.j3);
                    check_field("weight_out0", want.w0, got.w0);
                    check_field("weight_out1", want.w1, got.w1);
                    check_field("weight_out2", want.w2, got.w2);
                    check_field("weight_out3", want.w3, got.w3);
                    check_field("dominant_slot", 8'(want.dom_slot), 8'(got.dom_slot));
                    check_field("dominant_joint", want.dom_joint, got.dom_joint);
                end
            end
        end
    end

    // ready pattern: random stall per item, free-running stretches when asked
    initial begin : result_stall
        int stall;
        forever begin
            @(negedge aclk);
            if (rx_enable && !rx_free_run) begin
                stall = $urandom_range(0, 7);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
                while (!m_tvalid) @(posedge aclk);
            end else begin
                m_tready <= rx_enable;
            end
        end
    end

    task automatic test_directed_extremes;
        logic [15:0] ji [4];
        logic [15:0] wi [4];
        drain_and_configure(9'd0);
        // nothing mapped: zero total falls back to slot 0
        ji = '{16'hFFFF, 16'd0, 16'd1, 16'd2};
        wi = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_vertex(ji, wi);
        drain_and_configure(9'd256);
        send_write(8'd0, 8'd17);
        send_write(8'd1, 8'd0);
        send_write(8'd2, 8'd200);
        send_write(8'd3, UNMAPPED);
        send_write(8'd255, 8'd254);
        ji = '{16'd0, 16'd1, 16'd2, 16'd255};
        wi = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_vertex(ji, wi);
        wi = '{16'd0, 16'd0, 16'd0, 16'd0};
        send_vertex(ji, wi);
        wi = '{16'd1, 16'd0, 16'd0, 16'd0};
        send_vertex(ji, wi);
        wi = '{16'd1, 16'd1, 16'd1, 16'd0};
        send_vertex(ji, wi);
        wi = '{16'd0, 16'hFFFF, 16'd1, 16'd1};
        send_vertex(ji, wi);
        ji = '{16'd3, 16'd256, 16'hFFFF, 16'd2};
        wi = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3};
        send_vertex(ji, wi);
        // unmapped slot 0 with zero total
        send_write(8'd0, UNMAPPED);
        ji = '{16'd5, 16'd6, 16'd7, 16'd8};
        send_vertex(ji, wi);
        drain_and_configure(9'd511);
        ji = '{16'd255, 16'd2, 16'd1, 16'd256};
        wi = '{16'd2, 16'd2, 16'd5, 16'd9};
        send_vertex(ji, wi);
        drain_and_configure(9'd2);
        send_vertex(ji, wi);
    endtask

    task automatic test_random_vertices(input int n, input logic [8:0] count);
        logic [15:0] ji [4];
        logic [15:0] wi [4];
        int lim;
        drain_and_configure(count);
        lim = (count > 9'd256) ? 256 : int'(count);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 50) begin
                tx_free_run = !tx_free_run;
                rx_free_run = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 5) == 0) begin
                send_write(8'($urandom),
                           ($urandom_range(0, 7) == 0) ? UNMAPPED : 8'($urandom));
            end else begin
                foreach (ji[k]) begin
                    case ($urandom_range(0, 9))
                        0: ji[k] = 16'($urandom);
                        1: ji[k] = 16'hFFFF - 16'($urandom_range(0, 3));
                        default: ji[k] = 16'($urandom_range(0, (lim == 0) ? 3 : lim + 1));
                    endcase
                    case ($urandom_range(0, 7))
                        0: wi[k] = 16'd0;
                        1: wi[k] = 16'hFFFF;
                        2: wi[k] = 16'($urandom_range(0, 3));
                        default: wi[k] = 16'($urandom);
                    endcase
                end
                send_vertex(ji, wi);
            end
        end
        tx_free_run = 1'b0;
        rx_free_run = 1'b0;
    endtask

    initial begin
        foreach (joint_map[i]) joint_map[i] = UNMAPPED;
        active_joints = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        rx_enable = 1'b1;
        test_directed_extremes();
        // fill the table so most lookups hit
        drain_and_configure(9'd256);
        for (int i = 0; i < 256; i++) send_write(i[7:0], 8'($urandom_range(0, 254)));
        test_random_vertices(380, 9'd256);
        test_random_vertices(300, 9'd37);
        test_random_vertices(200, 9'd1);
        test_random_vertices(200, 9'd300);
        test_random_vertices(100, 9'd0);
        while (pending_vertices.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (errors == 0) begin
            $display("skin_weight_quantizer_unit_test: PASS");
        end else begin
            $display("skin_weight_quantizer_unit_test: FAIL");
        end
        $finish;
    end
endmodule

/* skin_weight_quantizer_unit.f */
rtl/core/swq_pkg.sv
rtl/core/swq_div.sv
rtl/core/skin_weight_quantizer_unit.sv
tb/skin_weight_quantizer_unit_test.sv
